// ===== rtl/rlom_pkg.sv =====
// Shared types, codes and sizes for the run-length offset map.
// Used by every module in this folder; depends on nothing.
`default_nettype none

package rlom_pkg;

  localparam int MAX_RUNS = 1024;
  localparam int IDX_W    = $clog2(MAX_RUNS);
  localparam int CNT_W    = $clog2(MAX_RUNS + 1);

  localparam int LEN_W  = 32;
  localparam int FILE_W = 16;
  localparam int LINE_W = 24;
  localparam int COL_W  = 16;
  localparam int SPAN_W = 16;
  localparam int ALU_W  = LEN_W + 1;

  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_LOOKUP = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [LEN_W-1:0]  start;
    logic [FILE_W-1:0] file;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  column;
    logic              advancing;
  } run_rec_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    run_rec_t         wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_A_SUM,
    ST_A_RLEN,
    ST_A_COL,
    ST_A_NEW,
    ST_L_LAST,
    ST_L_CLAMP,
    ST_L_PROBE,
    ST_L_CMP,
    ST_L_FETCH,
    ST_L_COL,
    ST_CLR,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/run_length_offset_map.sv =====
// Top level of the run-length offset map: sequencer, run table and shared ALU.
// Depends on rlom_pkg, rlom_alu and rlom_ram.
`default_nettype none

// Channel  Handshake                 Payload
// -------  ------------------------  ----------------------------------------------
// in       in_valid / in_ready       mode, file_id, line, column, span_length,
//                                    advance, offset
// out      out_valid / out_ready     status, found_file, found_line, found_column,
//                                    runs_in_use, mapped_length
//
// One beat in gives one beat out. in_ready is high only while the sequencer is idle.
// Lookup is a binary search of P probes, P being about log2 of the runs in use (10 for
// a full table); each probe uses the single table read port and then the ALU.
// Reset empties the map; table contents are not cleared and unwritten ones go unused.
// A result waits in the output register; a new beat may be taken meanwhile, and the
// sequencer holds in its final state only if the previous result is still not taken.

module run_length_offset_map (
  input  logic                          clk,
  input  logic                          rst,

  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    mode,
  input  logic [rlom_pkg::FILE_W-1:0]   file_id,
  input  logic [rlom_pkg::LINE_W-1:0]   line,
  input  logic [rlom_pkg::COL_W-1:0]    column,
  input  logic [rlom_pkg::SPAN_W-1:0]   span_length,
  input  logic                          advance,
  input  logic [rlom_pkg::LEN_W-1:0]    offset,

  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    status,
  output logic [rlom_pkg::FILE_W-1:0]   found_file,
  output logic [rlom_pkg::LINE_W-1:0]   found_line,
  output logic [rlom_pkg::COL_W-1:0]    found_column,
  output logic [rlom_pkg::CNT_W-1:0]    runs_in_use,
  output logic [rlom_pkg::LEN_W-1:0]    mapped_length
);

  // sequencer state and map bookkeeping
  rlom_pkg::state_t state, state_next;
  logic [rlom_pkg::CNT_W-1:0] entry_count;
  logic [rlom_pkg::LEN_W-1:0] total_length;

  // captured beat
  logic [rlom_pkg::FILE_W-1:0] req_file;
  logic [rlom_pkg::LINE_W-1:0] req_line;
  logic [rlom_pkg::COL_W-1:0]  req_col;
  logic [rlom_pkg::SPAN_W-1:0] req_len;
  logic                        req_adv;
  logic [rlom_pkg::LEN_W-1:0]  req_off;   // clamped to the last byte during lookup

  // working registers
  logic [rlom_pkg::LEN_W-1:0] new_total;
  logic [rlom_pkg::LEN_W-1:0] run_len;
  logic [rlom_pkg::LEN_W-1:0] last_byte;
  logic [rlom_pkg::LEN_W-1:0] delta;
  logic                       delta_ok;
  logic [rlom_pkg::CNT_W-1:0] lo, hi;

  // result being built
  logic [1:0]                  res_status;
  logic [rlom_pkg::FILE_W-1:0] res_file;
  logic [rlom_pkg::LINE_W-1:0] res_line;
  logic [rlom_pkg::COL_W-1:0]  res_col;

  // shared units
  rlom_pkg::alu_req_t         alu_req;
  logic [rlom_pkg::ALU_W:0]   alu_res;
  rlom_pkg::ram_req_t         ram_req;
  rlom_pkg::run_rec_t         rd;

  rlom_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  rlom_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (rd)
  );

  logic                       in_accept;
  logic                       out_free;
  logic [rlom_pkg::CNT_W-1:0] last_idx;
  logic [rlom_pkg::CNT_W-1:0] span;
  logic [rlom_pkg::CNT_W-1:0] mid;
  logic                       more;
  logic                       run_one, span_one;
  logic                       key_match, col_next_hit;
  logic                       merge_adv, merge_rep, table_full;

  assign in_ready  = (state == rlom_pkg::ST_IDLE);
  assign in_accept = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  assign last_idx = entry_count - rlom_pkg::CNT_W'(1);
  assign span     = hi - lo;
  assign more     = span > rlom_pkg::CNT_W'(1);
  assign mid      = lo + (span >> 1);

  // merge decision against the last run, valid in ST_A_COL
  assign run_one      = run_len == rlom_pkg::LEN_W'(1);
  assign span_one     = req_len == rlom_pkg::SPAN_W'(1);
  assign key_match    = (rd.file == req_file) && (rd.line == req_line);
  assign col_next_hit = alu_res == (rlom_pkg::ALU_W + 1)'(req_col);
  assign merge_adv    = key_match && (rd.advancing || run_one) && (req_adv || span_one)
                        && col_next_hit;
  assign merge_rep    = key_match && (!rd.advancing || run_one) && (!req_adv || span_one)
                        && (rd.column == req_col);
  assign table_full   = entry_count >= rlom_pkg::CNT_W'(rlom_pkg::MAX_RUNS);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      rlom_pkg::ST_IDLE: begin
        if (in_accept) begin
          unique case (mode)
            rlom_pkg::MODE_APPEND: state_next = rlom_pkg::ST_A_SUM;
            rlom_pkg::MODE_LOOKUP: state_next = rlom_pkg::ST_L_LAST;
            rlom_pkg::MODE_CLEAR:  state_next = rlom_pkg::ST_CLR;
            default:               state_next = rlom_pkg::ST_DONE;
          endcase
        end
      end
      rlom_pkg::ST_A_SUM: begin
        if (req_len == '0 || alu_res[rlom_pkg::LEN_W]) begin
          state_next = rlom_pkg::ST_DONE;
        end else if (entry_count == '0) begin
          state_next = rlom_pkg::ST_A_NEW;
        end else begin
          state_next = rlom_pkg::ST_A_RLEN;
        end
      end
      rlom_pkg::ST_A_RLEN: state_next = rlom_pkg::ST_A_COL;
      rlom_pkg::ST_A_COL: begin
        if (merge_adv || merge_rep || table_full) begin
          state_next = rlom_pkg::ST_DONE;
        end else begin
          state_next = rlom_pkg::ST_A_NEW;
        end
      end
      rlom_pkg::ST_A_NEW: state_next = rlom_pkg::ST_DONE;
      rlom_pkg::ST_L_LAST: begin
        if (entry_count == '0 || total_length == '0) begin
          state_next = rlom_pkg::ST_DONE;
        end else begin
          state_next = rlom_pkg::ST_L_CLAMP;
        end
      end
      rlom_pkg::ST_L_CLAMP: state_next = rlom_pkg::ST_L_PROBE;
      rlom_pkg::ST_L_PROBE: state_next = more ? rlom_pkg::ST_L_CMP : rlom_pkg::ST_L_FETCH;
      rlom_pkg::ST_L_CMP:   state_next = rlom_pkg::ST_L_PROBE;
      rlom_pkg::ST_L_FETCH: state_next = rlom_pkg::ST_L_COL;
      rlom_pkg::ST_L_COL:   state_next = rlom_pkg::ST_DONE;
      rlom_pkg::ST_CLR:     state_next = rlom_pkg::ST_DONE;
      rlom_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = rlom_pkg::ST_IDLE;
        end
      end
      default: state_next = rlom_pkg::ST_IDLE;
    endcase
  end

  // ALU operands and table port controls
  always_comb begin
    alu_req       = '{op: rlom_pkg::ALU_ADD, a: '0, b: '0};
    ram_req       = '0;
    ram_req.raddr = last_idx[rlom_pkg::IDX_W-1:0];
    ram_req.waddr = last_idx[rlom_pkg::IDX_W-1:0];
    ram_req.wdata = rd;
    unique case (state)
      rlom_pkg::ST_A_SUM: begin
        // overflow check of the new total; fetch the last run meanwhile
        alu_req = '{op: rlom_pkg::ALU_ADD, a: rlom_pkg::ALU_W'(total_length),
                    b: rlom_pkg::ALU_W'(req_len)};
        ram_req.re = 1'b1;
      end
      rlom_pkg::ST_A_RLEN: begin
        alu_req = '{op: rlom_pkg::ALU_SUB, a: rlom_pkg::ALU_W'(total_length),
                    b: rlom_pkg::ALU_W'(rd.start)};
      end
      rlom_pkg::ST_A_COL: begin
        // column just past the last run, compared without wrap
        alu_req = '{op: rlom_pkg::ALU_ADD, a: rlom_pkg::ALU_W'(rd.column),
                    b: rlom_pkg::ALU_W'(run_len)};
        ram_req.we              = merge_adv || merge_rep;
        ram_req.wdata.advancing = merge_adv;
      end
      rlom_pkg::ST_A_NEW: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = entry_count[rlom_pkg::IDX_W-1:0];
        ram_req.wdata = '{start: total_length, file: req_file, line: req_line,
                          column: req_col, advancing: req_adv || span_one};
      end
      rlom_pkg::ST_L_LAST: begin
        alu_req = '{op: rlom_pkg::ALU_SUB, a: rlom_pkg::ALU_W'(total_length),
                    b: rlom_pkg::ALU_W'(1)};
      end
      rlom_pkg::ST_L_CLAMP: begin
        alu_req = '{op: rlom_pkg::ALU_SUB, a: rlom_pkg::ALU_W'(last_byte),
                    b: rlom_pkg::ALU_W'(req_off)};
      end
      rlom_pkg::ST_L_PROBE: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = more ? mid[rlom_pkg::IDX_W-1:0] : lo[rlom_pkg::IDX_W-1:0];
      end
      rlom_pkg::ST_L_CMP, rlom_pkg::ST_L_FETCH: begin
        alu_req = '{op: rlom_pkg::ALU_SUB, a: rlom_pkg::ALU_W'(req_off),
                    b: rlom_pkg::ALU_W'(rd.start)};
      end
      rlom_pkg::ST_L_COL: begin
        alu_req = '{op: rlom_pkg::ALU_ADD, a: rlom_pkg::ALU_W'(rd.column),
                    b: (rd.advancing && delta_ok) ? rlom_pkg::ALU_W'(delta) : '0};
      end
      default: ;
    endcase
  end

  // datapath and bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= rlom_pkg::ST_IDLE;
      out_valid    <= 1'b0;
      entry_count  <= '0;
      total_length <= '0;
    end else begin
      state <= state_next;
      // load a finished result, or drop the beat the sink just took
      if (state == rlom_pkg::ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        rlom_pkg::ST_IDLE: begin
          if (in_accept) begin
            req_file   <= file_id;
            req_line   <= line;
            req_col    <= column;
            req_len    <= span_length;
            req_adv    <= advance;
            req_off    <= offset;
            res_status <= rlom_pkg::STATUS_OK;
            res_file   <= '0;
            res_line   <= '0;
            res_col    <= '0;
          end
        end
        rlom_pkg::ST_A_SUM: begin
          new_total <= alu_res[rlom_pkg::LEN_W-1:0];
          if (req_len != '0 && alu_res[rlom_pkg::LEN_W]) begin
            res_status <= rlom_pkg::STATUS_FULL;
          end
        end
        rlom_pkg::ST_A_RLEN: run_len <= alu_res[rlom_pkg::LEN_W-1:0];
        rlom_pkg::ST_A_COL: begin
          if (merge_adv || merge_rep) begin
            total_length <= new_total;
          end else if (table_full) begin
            res_status <= rlom_pkg::STATUS_FULL;
          end
        end
        rlom_pkg::ST_A_NEW: begin
          entry_count  <= entry_count + rlom_pkg::CNT_W'(1);
          total_length <= new_total;
        end
        rlom_pkg::ST_L_LAST: begin
          last_byte <= alu_res[rlom_pkg::LEN_W-1:0];
          lo        <= '0;
          hi        <= entry_count;
          if (entry_count == '0 || total_length == '0) begin
            res_status <= rlom_pkg::STATUS_EMPTY;
          end
        end
        rlom_pkg::ST_L_CLAMP: begin
          // borrow: offset lies past the last mapped byte
          if (alu_res[rlom_pkg::ALU_W]) begin
            req_off <= last_byte;
          end
        end
        rlom_pkg::ST_L_CMP: begin
          if (!alu_res[rlom_pkg::ALU_W]) begin
            lo <= mid;
          end else begin
            hi <= mid;
          end
        end
        rlom_pkg::ST_L_FETCH: begin
          delta    <= alu_res[rlom_pkg::LEN_W-1:0];
          delta_ok <= !alu_res[rlom_pkg::ALU_W];
        end
        rlom_pkg::ST_L_COL: begin
          res_file <= rd.file;
          res_line <= rd.line;
          res_col  <= (|alu_res[rlom_pkg::ALU_W:rlom_pkg::COL_W]) ? '1
                      : alu_res[rlom_pkg::COL_W-1:0];
        end
        rlom_pkg::ST_CLR: begin
          entry_count  <= '0;
          total_length <= '0;
        end
        rlom_pkg::ST_DONE: begin
          if (out_free) begin
            status        <= res_status;
            found_file    <= res_file;
            found_line    <= res_line;
            found_column  <= res_col;
            runs_in_use   <= entry_count;
            mapped_length <= total_length;
          end
        end
        default: ;
      endcase
    end
  end

  // an empty table and a zero length always go together
  a_empty_consistent: assert property (@(posedge clk) disable iff (rst)
    (entry_count == '0) == (total_length == '0))
    else $error("run count and mapped length disagree on emptiness");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= rlom_pkg::CNT_W'(rlom_pkg::MAX_RUNS))
    else $error("run count above table depth");

  a_search_window: assert property (@(posedge clk) disable iff (rst)
    (state == rlom_pkg::ST_L_PROBE) |-> (lo < hi))
    else $error("binary search window collapsed");

  a_write_only_append: assert property (@(posedge clk) disable iff (rst)
    ram_req.we |-> (state == rlom_pkg::ST_A_COL || state == rlom_pkg::ST_A_NEW))
    else $error("run table written outside an append");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> !in_ready)
    else $error("sequencer did not leave idle after taking a beat");

endmodule

`default_nettype wire

// ===== rtl/rlom_alu.sv =====
// Shared 33-bit add/subtract unit of the run-length offset map.
// Depends on rlom_pkg; the top bit of a subtract is the borrow.
`default_nettype none

module rlom_alu (
  input  rlom_pkg::alu_req_t         req,
  output logic [rlom_pkg::ALU_W:0]   res
);

  always_comb begin
    unique case (req.op)
      rlom_pkg::ALU_ADD: res = {1'b0, req.a} + {1'b0, req.b};
      rlom_pkg::ALU_SUB: res = {1'b0, req.a} - {1'b0, req.b};
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/rlom_ram.sv =====
// Run table storage: one write port, one registered read port.
// Depends on rlom_pkg for the record type and depth.
`default_nettype none

module rlom_ram (
  input  logic               clk,
  input  rlom_pkg::ram_req_t req,
  output rlom_pkg::run_rec_t rdata
);

  rlom_pkg::run_rec_t mem [rlom_pkg::MAX_RUNS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sim/run_length_offset_map_tb.sv =====
// Self-checking testbench for run_length_offset_map: append, lookup and clear beats.
// Holds its own model of the run table and compares each result beat field by field.
// Depends on rlom_pkg and the run_length_offset_map RTL.
`timescale 1ns / 1ps

module run_length_offset_map_tb;

  localparam int          HALF_PERIOD = 4;
  localparam int          RESET_CYCLES = 7;
  localparam logic [1:0]  MODE_UNUSED = 2'd3;
  // Limit on the whole run, with a wide margin over the slowest legal run.
  localparam longint      CYCLE_LIMIT = 4_000_000;
  localparam int          SETTLE_CYCLES = 60;
  localparam int          RANDOM_PER_PHASE = 40;

  typedef struct packed {
    logic [1:0]                  mode;
    logic [rlom_pkg::FILE_W-1:0] file_id;
    logic [rlom_pkg::LINE_W-1:0] line;
    logic [rlom_pkg::COL_W-1:0]  column;
    logic [rlom_pkg::SPAN_W-1:0] span_length;
    logic                        advance;
    logic [rlom_pkg::LEN_W-1:0]  offset;
  } map_req_t;

  localparam int REQ_W = $bits(map_req_t);

  typedef struct packed {
    logic [1:0]                  status;
    logic [rlom_pkg::FILE_W-1:0] found_file;
    logic [rlom_pkg::LINE_W-1:0] found_line;
    logic [rlom_pkg::COL_W-1:0]  found_column;
    logic [rlom_pkg::CNT_W-1:0]  runs_in_use;
    logic [rlom_pkg::LEN_W-1:0]  mapped_length;
  } map_result_t;

  // Mirror of the run table plus the queue of coordinates and counts still owed.
  class offset_map_board;
    logic [rlom_pkg::LEN_W-1:0]  run_start     [rlom_pkg::MAX_RUNS];
    logic [rlom_pkg::FILE_W-1:0] run_file      [rlom_pkg::MAX_RUNS];
    logic [rlom_pkg::LINE_W-1:0] run_line      [rlom_pkg::MAX_RUNS];
    logic [rlom_pkg::COL_W-1:0]  run_column    [rlom_pkg::MAX_RUNS];
    logic                        run_advancing [rlom_pkg::MAX_RUNS];
    int unsigned                 entry_count;
    logic [rlom_pkg::LEN_W-1:0]  total_length;
    map_result_t                 owed_results[$];
    int                          failures;

    function new();
      entry_count  = 0;
      total_length = '0;
      failures     = 0;
    endfunction

    // Apply one accepted request beat to the table and queue the result it owes.
    function void note_request(map_req_t r);
      map_result_t                res;
      int unsigned                k, lo, hi, mid;
      logic [rlom_pkg::LEN_W-1:0] rlen, off;
      logic [63:0]                col_sum;
      bit                         run_adv, merged;
      bit                         run_may_adv, run_may_rep, new_may_adv, new_may_rep;
      res = '0;
      case (r.mode)
        rlom_pkg::MODE_APPEND: begin
          if (r.span_length == 0) begin
            // empty span: nothing moves
          end else if (64'(total_length) + 64'(r.span_length) > 64'hFFFF_FFFF) begin
            res.status = rlom_pkg::STATUS_FULL;
          end else begin
            merged = 1'b0;
            if (entry_count > 0) begin
              k    = entry_count - 1;
              rlen = total_length - run_start[k];
              if (run_file[k] == r.file_id && run_line[k] == r.line) begin
                run_adv     = run_advancing[k];
                run_may_adv = run_adv || rlen == 1;
                run_may_rep = !run_adv || rlen == 1;
                new_may_adv = r.advance || r.span_length == 1;
                new_may_rep = !r.advance || r.span_length == 1;
                // column sum compared at full width, no 16-bit wrap
                if (run_may_adv && new_may_adv &&
                    64'(run_column[k]) + 64'(rlen) == 64'(r.column)) begin
                  run_advancing[k] = 1'b1;
                  merged = 1'b1;
                end else if (run_may_rep && new_may_rep && run_column[k] == r.column) begin
                  run_advancing[k] = 1'b0;
                  merged = 1'b1;
                end
              end
            end
            if (merged) begin
              total_length += r.span_length;
            end else if (entry_count >= rlom_pkg::MAX_RUNS) begin
              res.status = rlom_pkg::STATUS_FULL;
            end else begin
              run_start[entry_count]     = total_length;
              run_file[entry_count]      = r.file_id;
              run_line[entry_count]      = r.line;
              run_column[entry_count]    = r.column;
              run_advancing[entry_count] = r.advance || r.span_length == 1;
              entry_count++;
              total_length += r.span_length;
            end
          end
        end
        rlom_pkg::MODE_LOOKUP: begin
          if (entry_count == 0 || total_length == 0) begin
            res.status = rlom_pkg::STATUS_EMPTY;
          end else begin
            off = (r.offset >= total_length) ? total_length - 1 : r.offset;
            lo  = 0;
            hi  = entry_count;
            while (hi - lo > 1) begin
              mid = lo + (hi - lo) / 2;
              if (run_start[mid] <= off) lo = mid;
              else hi = mid;
            end
            res.found_file = run_file[lo];
            res.found_line = run_line[lo];
            col_sum = 64'(run_column[lo]);
            if (run_advancing[lo]) col_sum += 64'(off - run_start[lo]);
            res.found_column = (col_sum > 64'hFFFF) ? 16'hFFFF : col_sum[15:0];
          end
        end
        rlom_pkg::MODE_CLEAR: begin
          entry_count  = 0;
          total_length = '0;
        end
        default: ;
      endcase
      res.runs_in_use   = entry_count[rlom_pkg::CNT_W-1:0];
      res.mapped_length = total_length;
      owed_results.push_back(res);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        failures++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
    endfunction

    // Match one accepted result beat against the oldest owed result.
    function void check_answer(map_result_t got);
      map_result_t want;
      if (owed_results.size() == 0) begin
        failures++;
        $display("%0t: result beat with nothing owed, status %0d, mapped_length 0x%0h",
                 $time, got.status, got.mapped_length);
        return;
      end
      want = owed_results.pop_front();
      compare_field("status",        64'(want.status),        64'(got.status));
      compare_field("found_file",    64'(want.found_file),    64'(got.found_file));
      compare_field("found_line",    64'(want.found_line),    64'(got.found_line));
      compare_field("found_column",  64'(want.found_column),  64'(got.found_column));
      compare_field("runs_in_use",   64'(want.runs_in_use),   64'(got.runs_in_use));
      compare_field("mapped_length", 64'(want.mapped_length), 64'(got.mapped_length));
    endfunction
  endclass

  // Drive every input to a known value from time zero.
  logic                         clk         = 1'b0;
  logic                         rst         = 1'b1;
  logic                         in_valid    = 1'b0;
  logic                         in_ready;
  logic [1:0]                   mode        = rlom_pkg::MODE_APPEND;
  logic [rlom_pkg::FILE_W-1:0]  file_id     = '0;
  logic [rlom_pkg::LINE_W-1:0]  line        = '0;
  logic [rlom_pkg::COL_W-1:0]   column      = '0;
  logic [rlom_pkg::SPAN_W-1:0]  span_length = '0;
  logic                         advance     = 1'b0;
  logic [rlom_pkg::LEN_W-1:0]   offset      = '0;
  logic                         out_valid;
  logic                         out_ready   = 1'b0;
  logic [1:0]                   status;
  logic [rlom_pkg::FILE_W-1:0]  found_file;
  logic [rlom_pkg::LINE_W-1:0]  found_line;
  logic [rlom_pkg::COL_W-1:0]   found_column;
  logic [rlom_pkg::CNT_W-1:0]   runs_in_use;
  logic [rlom_pkg::LEN_W-1:0]   mapped_length;

  int unsigned        send_idle_pct = 0;
  int unsigned        stall_pct     = 0;
  longint             cycle_count   = 0;
  offset_map_board    board         = new();

  run_length_offset_map dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .file_id       (file_id),
    .line          (line),
    .column        (column),
    .span_length   (span_length),
    .advance       (advance),
    .offset        (offset),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .found_file    (found_file),
    .found_line    (found_line),
    .found_column  (found_column),
    .runs_in_use   (runs_in_use),
    .mapped_length (mapped_length)
  );

  always #HALF_PERIOD clk = ~clk;

  // Stall the result channel at random; stall_pct of zero keeps it always ready.
  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= stall_pct);
  end

  // Sample result beats at the rising edge, where the handshake completes.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_answer({status, found_file, found_line, found_column,
                          runs_in_use, mapped_length});
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic map_req_t span_req(logic [rlom_pkg::FILE_W-1:0] f,
                                        logic [rlom_pkg::LINE_W-1:0] l,
                                        logic [rlom_pkg::COL_W-1:0] c,
                                        logic [rlom_pkg::SPAN_W-1:0] n,
                                        logic adv);
    map_req_t r;
    r             = '0;
    r.mode        = rlom_pkg::MODE_APPEND;
    r.file_id     = f;
    r.line        = l;
    r.column      = c;
    r.span_length = n;
    r.advance     = adv;
    return r;
  endfunction

  function automatic map_req_t probe_req(logic [rlom_pkg::LEN_W-1:0] off);
    map_req_t r;
    r        = '0;
    r.mode   = rlom_pkg::MODE_LOOKUP;
    r.offset = off;
    return r;
  endfunction

  function automatic map_req_t mode_req(logic [1:0] m);
    map_req_t r;
    r      = '0;
    r.mode = m;
    return r;
  endfunction

  // Mostly short spans; now and then empty, one byte, or up to the full field.
  function automatic logic [rlom_pkg::SPAN_W-1:0] pick_length();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 5) return '0;
    if (sel < 10) return 16'hFFFF;
    if (sel < 20) return 16'd1;
    if (sel < 30) return rlom_pkg::SPAN_W'($urandom());
    return rlom_pkg::SPAN_W'($urandom_range(6, 1));
  endfunction

  // Build a span that tries to continue the last run; the advance bit is random,
  // so some of these break the run and open a new one instead.
  function automatic map_req_t merge_request();
    map_req_t                   r;
    int unsigned                k;
    logic [rlom_pkg::LEN_W-1:0] rlen;
    r = span_req(rlom_pkg::FILE_W'($urandom()), rlom_pkg::LINE_W'($urandom()),
                 rlom_pkg::COL_W'($urandom()), pick_length(), 1'($urandom_range(1)));
    if (board.entry_count != 0) begin
      k         = board.entry_count - 1;
      rlen      = board.total_length - board.run_start[k];
      r.file_id = board.run_file[k];
      r.line    = board.run_line[k];
      // advancing continuation may wrap past 16 bits; the block must not merge then
      r.column  = r.advance ? board.run_column[k] + rlen[rlom_pkg::COL_W-1:0]
                            : board.run_column[k];
    end
    return r;
  endfunction

  function automatic map_req_t random_request();
    map_req_t                   r;
    int unsigned                sel, pick;
    logic [rlom_pkg::LEN_W-1:0] t;
    sel = $urandom_range(99);
    t   = board.total_length;
    if (sel < 30) begin
      r = merge_request();
    end else if (sel < 45) begin
      // new run from a small pool of files and lines, sometimes anywhere
      r = span_req($urandom_range(1) ? rlom_pkg::FILE_W'($urandom_range(3))
                                     : rlom_pkg::FILE_W'($urandom()),
                   $urandom_range(1) ? rlom_pkg::LINE_W'($urandom_range(7))
                                     : rlom_pkg::LINE_W'($urandom()),
                   rlom_pkg::COL_W'($urandom()), pick_length(), 1'($urandom_range(1)));
    end else if (sel < 80) begin
      pick = $urandom_range(9);
      r = probe_req('0);
      if (t == 0 || pick == 0) r.offset = $urandom();
      else if (pick == 1) r.offset = t + $urandom_range(3);
      else if (pick == 2)
        r.offset = board.run_start[$urandom_range(board.entry_count - 1)] - $urandom_range(1);
      else r.offset = $urandom_range(t - 1);
    end else if (sel < 82) begin
      r = mode_req(rlom_pkg::MODE_CLEAR);
    end else begin
      // noise: every field random, unused mode included
      r = REQ_W'({$urandom(), $urandom(), $urandom(), $urandom()});
      if (sel < 86) r.mode = MODE_UNUSED;
    end
    return r;
  endfunction

  // Offer one request beat, hold it until accepted, then record it.
  task automatic send_beat(input map_req_t r);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    mode        = r.mode;
    file_id     = r.file_id;
    line        = r.line;
    column      = r.column;
    span_length = r.span_length;
    advance     = r.advance;
    offset      = r.offset;
    in_valid    = 1'b1;
    do @(posedge clk); while (!in_ready);
    board.note_request(r);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Hold the sender until every owed result beat has come back.
  task automatic await_results();
    while (board.owed_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_random(input int unsigned n);
    repeat (n) send_beat(random_request());
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty map, zero span, unused mode, saturation, clamping, merge kinds.
    send_beat(probe_req(32'd0));
    send_beat(span_req(16'd1, 24'd1, 16'd1, 16'd0, 1'b1));
    send_beat(mode_req(MODE_UNUSED));
    send_beat(span_req(16'hFFFF, 24'hFFFFFF, 16'hFFF0, 16'd20, 1'b1));
    send_beat(probe_req(32'd19));                 // column runs past 65535
    send_beat(probe_req(32'hFFFF_FFFF));          // clamp to last byte
    send_beat(span_req(16'hFFFF, 24'hFFFFFF, 16'd4, 16'd3, 1'b1));  // wrapped column
    send_beat(span_req(16'hFFFF, 24'hFFFFFF, 16'd7, 16'd2, 1'b1));  // advancing merge
    send_beat(span_req(16'hFFFF, 24'hFFFFFF, 16'd7, 16'd5, 1'b0));  // new repeating run
    send_beat(span_req(16'hFFFF, 24'hFFFFFF, 16'd7, 16'd4, 1'b0));  // repeating merge
    send_beat(span_req(16'hFFFF, 24'hFFFFFF, 16'd7, 16'd1, 1'b1));  // one byte repeats
    send_beat(span_req(16'd1, 24'd2, 16'd100, 16'd1, 1'b0));        // one-byte run
    send_beat(span_req(16'd1, 24'd2, 16'd100, 16'd3, 1'b0));        // it turns repeating
    send_beat(span_req(16'd1, 24'd2, 16'd0, 16'd1, 1'b1));
    send_beat(span_req(16'd1, 24'd2, 16'd1, 16'd2, 1'b1));          // it turns advancing
    send_beat(span_req(16'd2, 24'd2, 16'd3, 16'd1, 1'b1));          // file differs
    send_beat(span_req(16'd2, 24'd3, 16'd4, 16'd1, 1'b1));          // line differs
    send_beat(probe_req(32'd0));
    send_beat(probe_req(32'd20));
    send_beat(probe_req(32'd22));
    send_beat(probe_req(32'd25));
    send_beat(probe_req(32'd34));
    send_beat(probe_req(32'd42));
    send_beat(probe_req(32'd1000));
    send_beat(mode_req(rlom_pkg::MODE_CLEAR));
    send_beat(probe_req(32'd5));
    await_results();

    // Fill every run slot, then push one beat that cannot merge and one that tries to.
    send_idle_pct = 20;
    stall_pct     = 20;
    for (int i = 0; i < rlom_pkg::MAX_RUNS; i++)
      send_beat(span_req(rlom_pkg::FILE_W'(i), rlom_pkg::LINE_W'(i),
                         rlom_pkg::COL_W'($urandom()),
                         rlom_pkg::SPAN_W'($urandom_range(3, 1)), 1'($urandom_range(1))));
    send_beat(span_req(16'hABCD, 24'd1, 16'd0, 16'd1, 1'b1));
    send_beat(merge_request());
    repeat (30) send_beat(probe_req($urandom_range(board.total_length + 8)));
    send_beat(mode_req(rlom_pkg::MODE_CLEAR));
    await_results();

    // Random traffic under each idling pattern, draining halfway through each.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 56; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 56; end
        default: begin send_idle_pct = 20; stall_pct = 20; end
      endcase
      run_random(RANDOM_PER_PHASE / 2);
      await_results();
      run_random(RANDOM_PER_PHASE / 2);
    end

    await_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.failures == 0 && board.owed_results.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/rlom_pkg.sv
rtl/rlom_alu.sv
rtl/rlom_ram.sv
rtl/run_length_offset_map.sv
sim/run_length_offset_map_tb.sv
